// File: rtl/lfq_pkg.sv
// ----------------------------------------------------------------------------
// lfq_pkg
// Shared types and codes of the linked queue with unlink.
// ----------------------------------------------------------------------------
package lfq_pkg;

  localparam int UNIT_W    = 6;           // width of a unit identifier
  localparam int UNIT_SPAN = 2 ** UNIT_W; // identifiers that a request can name
  localparam int COUNT_W   = 7;           // width of the queued count

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_POP_EMPTY       = 2'd1,
    ST_PUSH_QUEUED     = 2'd2,
    ST_REMOVE_UNQUEUED = 2'd3
  } status_t;

  // One write command to a link table.
  typedef struct packed {
    logic              en;
    logic [UNIT_W-1:0] addr;
    logic [UNIT_W-1:0] data;
  } link_wr_t;

endpackage

// File: rtl/lfq_if.sv
// ----------------------------------------------------------------------------
// lfq_req_if / lfq_rsp_if
// Valid/ready channels for requests and results of the linked queue.
// ----------------------------------------------------------------------------
interface lfq_req_if;
  logic                      valid;
  logic                      ready;
  lfq_pkg::req_type_t        req_type;
  logic [lfq_pkg::UNIT_W-1:0] unit_id;

  modport source (output valid, output req_type, output unit_id, input ready);
  modport sink   (input valid, input req_type, input unit_id, output ready);
endinterface

interface lfq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lfq_pkg::UNIT_W-1:0]  popped_unit;
  logic                        popped_valid;
  logic [lfq_pkg::COUNT_W-1:0] queued_count;
  lfq_pkg::status_t            status;

  modport source (output valid, output popped_unit, output popped_valid,
                  output queued_count, output status, input ready);
  modport sink   (input valid, input popped_unit, input popped_valid,
                  input queued_count, input status, output ready);
endinterface

// File: rtl/lfq_link_mem.sv
// ----------------------------------------------------------------------------
// lfq_link_mem
// Next and previous link tables: one write port each, a shared read address,
// registered read data.
// ----------------------------------------------------------------------------
module lfq_link_mem #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  lfq_pkg::link_wr_t          next_wr,
  input  lfq_pkg::link_wr_t          prev_wr,
  input  logic                       rd_en,
  input  logic [lfq_pkg::UNIT_W-1:0] rd_addr,
  output logic [lfq_pkg::UNIT_W-1:0] rd_next,
  output logic [lfq_pkg::UNIT_W-1:0] rd_prev
);

  localparam int IW = $clog2(SLOTS);

  logic [IW-1:0] next_mem [SLOTS];
  logic [IW-1:0] prev_mem [SLOTS];
  logic [IW-1:0] next_q_r;
  logic [IW-1:0] prev_q_r;

  always_ff @(posedge clk) begin
    if (next_wr.en) begin
      next_mem[next_wr.addr[IW-1:0]] <= next_wr.data[IW-1:0];
    end
    if (prev_wr.en) begin
      prev_mem[prev_wr.addr[IW-1:0]] <= prev_wr.data[IW-1:0];
    end
    // hold the read data until the next read
    if (rd_en) begin
      next_q_r <= next_mem[rd_addr[IW-1:0]];
      prev_q_r <= prev_mem[rd_addr[IW-1:0]];
    end
  end

  assign rd_next = lfq_pkg::UNIT_W'(next_q_r);
  assign rd_prev = lfq_pkg::UNIT_W'(prev_q_r);

endmodule

// File: rtl/linked_fifo_with_unlink_top.sv
// ----------------------------------------------------------------------------
// linked_fifo_with_unlink_top
// FIFO of unit identifiers kept as a circular doubly linked list, with push,
// pop, remove of any queued unit, and count query.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                                       ends
//   in_req    sink       req_type, unit_id                             valid/ready
//   out_rsp   source     popped_unit, popped_valid, queued_count, st.  valid/ready
//
// Sequence: a request is taken in S_IDLE, which also reads the links of the
// target slot; S_EXEC finishes query, rejected requests, pop, remove and push
// onto an empty queue. Push onto a non-empty queue goes on through S_PUSH2,
// since it writes two entries of each link table and each table has a single
// write port. Reset clears control state and the queued bits; the link
// tables are not cleared. A result waits in the output register, and the
// next request is taken meanwhile; that request stalls in S_EXEC or S_PUSH2
// until the output register is free.
// ----------------------------------------------------------------------------
module linked_fifo_with_unlink_top #(
  parameter int NUM_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lfq_req_if.sink   in_req,
  lfq_rsp_if.source out_rsp
);

  // a request names at most UNIT_SPAN slots
  localparam int SLOTS = (NUM_SLOTS < lfq_pkg::UNIT_SPAN) ? NUM_SLOTS : lfq_pkg::UNIT_SPAN;
  localparam int IW    = $clog2(SLOTS);
  localparam int UW    = lfq_pkg::UNIT_W;
  localparam int CW    = lfq_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_PUSH2 = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [UW-1:0]      head_r, head_nxt;
  logic [UW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SLOTS-1:0]   queued_r, queued_nxt;

  lfq_pkg::req_type_t req_r;
  logic [UW-1:0]      unit_r;

  logic               out_valid_r, out_valid_nxt;
  logic [UW-1:0]      out_popped_r;
  logic               out_pv_r;
  logic [CW-1:0]      out_count_r;
  lfq_pkg::status_t   out_status_r;

  lfq_pkg::link_wr_t  next_wr, prev_wr;
  logic [UW-1:0]      rd_addr, rd_next, rd_prev;

  logic               in_xfer;
  logic               go;
  logic               finish;
  logic               unlink_en;
  logic [UW-1:0]      tgt;
  logic               in_rng;
  logic               unit_queued;
  logic [UW-1:0]      res_popped;
  logic               res_pv;
  lfq_pkg::status_t   res_status;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_xfer      = in_req.valid && in_req.ready;

  // finishing cycles need room in the output register
  assign go = !out_valid_r || out_rsp.ready;

  // pop reads the links of the head, every other request those of its unit
  assign rd_addr = (in_req.req_type == lfq_pkg::REQ_POP) ? head_r : in_req.unit_id;

  assign in_rng      = ({1'b0, unit_r} < CW'(SLOTS));
  assign unit_queued = in_rng && queued_r[unit_r[IW-1:0]];

  lfq_link_mem #(
    .SLOTS (SLOTS)
  ) u_links (
    .clk     (clk),
    .next_wr (next_wr),
    .prev_wr (prev_wr),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_next (rd_next),
    .rd_prev (rd_prev)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    queued_nxt = queued_r;
    next_wr    = '0;
    prev_wr    = '0;
    finish     = 1'b0;
    unlink_en  = 1'b0;
    tgt        = unit_r;
    res_popped = '0;
    res_pv     = 1'b0;
    res_status = lfq_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          unique case (req_r)
            lfq_pkg::REQ_PUSH: begin
              if (unit_queued || !in_rng) begin
                res_status = lfq_pkg::ST_PUSH_QUEUED;
                finish     = 1'b1;
              end else if (count_r == '0) begin
                // first unit links to itself
                next_wr    = '{en: 1'b1, addr: unit_r, data: unit_r};
                prev_wr    = '{en: 1'b1, addr: unit_r, data: unit_r};
                head_nxt   = unit_r;
                tail_nxt   = unit_r;
                count_nxt  = count_r + CW'(1);
                queued_nxt[unit_r[IW-1:0]] = 1'b1;
                finish     = 1'b1;
              end else begin
                // hook the neighbors first, the unit's own links in S_PUSH2
                next_wr   = '{en: 1'b1, addr: tail_r, data: unit_r};
                prev_wr   = '{en: 1'b1, addr: head_r, data: unit_r};
                state_nxt = S_PUSH2;
              end
            end
            lfq_pkg::REQ_POP: begin
              if (count_r == '0) begin
                res_status = lfq_pkg::ST_POP_EMPTY;
                finish     = 1'b1;
              end else begin
                res_popped = head_r;
                res_pv     = 1'b1;
                tgt        = head_r;
                unlink_en  = 1'b1;
              end
            end
            lfq_pkg::REQ_REMOVE: begin
              if (!unit_queued) begin
                res_status = lfq_pkg::ST_REMOVE_UNQUEUED;
                finish     = 1'b1;
              end else begin
                unlink_en = 1'b1;
              end
            end
            lfq_pkg::REQ_QUERY: begin
              finish = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_PUSH2: begin
        if (go) begin
          next_wr   = '{en: 1'b1, addr: unit_r, data: head_r};
          prev_wr   = '{en: 1'b1, addr: unit_r, data: tail_r};
          tail_nxt  = unit_r;
          count_nxt = count_r + CW'(1);
          queued_nxt[unit_r[IW-1:0]] = 1'b1;
          finish    = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // take the target out of the list: join its neighbors to each other, or empty the list if it was the only unit
    if (unlink_en) begin
      if (count_r == CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        next_wr = '{en: 1'b1, addr: rd_prev, data: rd_next};
        prev_wr = '{en: 1'b1, addr: rd_next, data: rd_prev};
        if (tgt == head_r) begin
          head_nxt = rd_next;
        end
        if (tgt == tail_r) begin
          tail_nxt = rd_prev;
        end
      end
      count_nxt = count_r - CW'(1);
      queued_nxt[tgt[IW-1:0]] = 1'b0;
      finish = 1'b1;
    end

    if (finish) begin
      state_nxt = S_IDLE;
    end

    // load on a finish, drop once taken
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the request and the result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r  <= in_req.req_type;
      unit_r <= in_req.unit_id;
    end
    if (finish) begin
      out_popped_r <= res_popped;
      out_pv_r     <= res_pv;
      out_count_r  <= count_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.popped_unit  = out_popped_r;
  assign out_rsp.popped_valid = out_pv_r;
  assign out_rsp.queued_count = out_count_r;
  assign out_rsp.status       = out_status_r;

  // queued bits and count agree
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(count_r))
    else $error("queued bits disagree with count");

  // head and tail are queued whenever the queue is not empty
  a_ends_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (queued_r[head_r[IW-1:0]] && queued_r[tail_r[IW-1:0]]))
    else $error("head or tail slot not queued");

  // no link write while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!next_wr.en && !prev_wr.en))
    else $error("link write in idle");

  // a finished request returns to idle with its result presented
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (state_r == S_IDLE) && out_valid_r)
    else $error("finish did not return to idle");

  // a popped unit is reported only with status ok
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pv_r) |-> (out_status_r == lfq_pkg::ST_OK))
    else $error("popped unit with error status");

endmodule
